// ----- hw/rtl/pidr_pkg.sv -----
package pidr_pkg;

    // field and datapath widths
    localparam int DATA_W    = 16;
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int SUM_W     = 32;
    localparam int ACC_W     = 64;
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W   = 32;
    localparam int DIV_D_W   = 16;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd4;

    // request to the shared multiplier
    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

// ----- hw/rtl/pid_regulator.sv -----
// Discrete PID regulator. Each measured sample yields one drive value,
// kp*e + ki*period*sum + kd*(e - previous e)/period scaled down by 256 (gains are
// signed Q8.8), saturated to signed 16 bits with o_output_clipped flagging the
// clamp. The error sum saturates at signed 32 bits. A period of zero acts as one.
// Each sample runs from acceptance to result through a short sequence of
// steps on one shared 34x18 multiplier and the bit-serial divider that
// scales the derivative term by the period; a new sample is taken only after
// the last one is through. The next sample is accepted once the sequencer is
// back in idle, even while the previous result still waits in the output
// register. Configure only while no sample is in flight.
module pid_regulator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pidr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pidr_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [pidr_pkg::DATA_W-1:0]   i_measured_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [pidr_pkg::DATA_W-1:0]   o_drive_value,
    output logic                                 o_output_clipped
);

    localparam int DW  = pidr_pkg::DATA_W;
    localparam int EW  = pidr_pkg::ERR_W;
    localparam int FW  = pidr_pkg::DIFF_W;
    localparam int SW  = pidr_pkg::SUM_W;
    localparam int AW  = pidr_pkg::ACC_W;
    localparam int MAW = pidr_pkg::MUL_A_W;
    localparam int MBW = pidr_pkg::MUL_B_W;
    localparam int PW  = pidr_pkg::PROD_W;
    localparam int NW  = pidr_pkg::DIV_N_W;
    localparam int YW  = AW - 8;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_KIP, S_IHI, S_ILO, S_P, S_DP, S_DIV_GO, S_DIV_WAIT,
        S_RND, S_FIN
    } t_state;

    t_state              r_state;
    logic [DW-1:0]       r_setpoint;
    logic [DW-1:0]       r_prop_gain;
    logic [DW-1:0]       r_integ_gain;
    logic [DW-1:0]       r_deriv_gain;
    logic [DW-1:0]       r_period;

    logic [EW-1:0]       r_e;
    logic [EW-1:0]       r_prev;
    logic [SW-1:0]       r_sum;
    logic [FW-1:0]       r_diff;
    logic [MAW-1:0]      r_kip;
    logic [AW-1:0]       r_acc;
    logic                r_dneg;
    logic                r_out_valid;
    logic [DW-1:0]       r_drive;
    logic                r_clip;

    logic [DW-1:0]       w_per_eff;
    logic [SW:0]         w_sum_ext;
    logic [SW-1:0]       n_sum;
    logic [FW-1:0]       n_diff;
    pidr_pkg::t_mul_req  w_mul_req;
    logic signed [PW-1:0] w_prod;
    logic [AW-1:0]       w_prod_ext;
    logic [MAW-1:0]      w_dp;
    logic [MAW-1:0]      w_dp_mag;
    logic                w_div_start;
    logic                w_div_done;
    logic [NW-1:0]       w_quot;
    logic [AW-1:0]       w_quot_ext;
    logic [YW-1:0]       w_y;
    logic                w_clip;
    logic [DW-1:0]       w_drive;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= '0;
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_period     <= DW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pidr_pkg::REG_SETPOINT:   r_setpoint   <= i_cfg_data;
                pidr_pkg::REG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                pidr_pkg::REG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                pidr_pkg::REG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                pidr_pkg::REG_PERIOD:     r_period     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_per_eff = (r_period == '0) ? DW'(1) : r_period;

    // saturating error sum and error difference
    always_comb begin
        w_sum_ext = {r_sum[SW-1], r_sum} + {{(SW+1-EW){r_e[EW-1]}}, r_e};
        if (w_sum_ext[SW] != w_sum_ext[SW-1]) begin
            n_sum = w_sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            n_sum = w_sum_ext[SW-1:0];
        end
        n_diff = {r_e[EW-1], r_e} - {r_prev[EW-1], r_prev};
    end

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_req.en = 1'b1;
        w_mul_req.a  = '0;
        w_mul_req.b  = '0;
        case (r_state)
            S_KIP: begin
                w_mul_req.a = {{(MAW-DW){r_integ_gain[DW-1]}}, r_integ_gain};
                w_mul_req.b = {{(MBW-DW){1'b0}}, w_per_eff};
            end
            S_IHI: begin
                w_mul_req.a = w_prod[MAW-1:0];
                w_mul_req.b = {{(MBW-SW/2){r_sum[SW-1]}}, r_sum[SW-1:SW/2]};
            end
            S_ILO: begin
                w_mul_req.a = r_kip;
                w_mul_req.b = {{(MBW-SW/2){1'b0}}, r_sum[SW/2-1:0]};
            end
            S_P: begin
                w_mul_req.a = {{(MAW-DW){r_prop_gain[DW-1]}}, r_prop_gain};
                w_mul_req.b = {{(MBW-EW){r_e[EW-1]}}, r_e};
            end
            S_DP: begin
                w_mul_req.a = {{(MAW-DW){r_deriv_gain[DW-1]}}, r_deriv_gain};
                w_mul_req.b = r_diff;
            end
            default: w_mul_req.en = 1'b0;
        endcase
    end

    pidr_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    assign w_prod_ext  = {{(AW-PW){w_prod[PW-1]}}, w_prod};
    assign w_dp        = w_prod[MAW-1:0];
    assign w_dp_mag    = w_dp[MAW-1] ? (MAW'(0) - w_dp) : w_dp;
    assign w_div_start = (r_state == S_DIV_GO);

    pidr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dp_mag[NW-1:0]),
        .i_den   (w_per_eff),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_quot_ext = r_dneg ? (AW'(0) - {{(AW-NW){1'b0}}, w_quot})
                               : {{(AW-NW){1'b0}}, w_quot};

    // accumulator already biased toward zero, so a plain shift truncates correctly
    always_comb begin
        w_y    = r_acc[AW-1:8];
        w_clip = !((&w_y[YW-1:DW-1]) || !(|w_y[YW-1:DW-1]));
        if (w_clip) begin
            w_drive = w_y[YW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            w_drive = w_y[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the final step reloads the output register itself
            if (r_out_valid && i_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_e     <= {r_setpoint[DW-1], r_setpoint}
                                   - {i_measured_value[DW-1], i_measured_value};
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_sum   <= n_sum;
                    r_diff  <= n_diff;
                    r_prev  <= r_e;
                    r_state <= S_KIP;
                end
                S_KIP: r_state <= S_IHI;
                S_IHI: begin
                    r_kip   <= w_prod[MAW-1:0];
                    r_state <= S_ILO;
                end
                S_ILO: begin
                    r_acc   <= {w_prod_ext[AW-SW/2-1:0], {(SW/2){1'b0}}};
                    r_state <= S_P;
                end
                S_P: begin
                    r_acc   <= r_acc + w_prod_ext;
                    r_state <= S_DP;
                end
                S_DP: begin
                    r_acc   <= r_acc + w_prod_ext;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_dneg  <= w_dp[MAW-1];
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_acc   <= r_acc + w_quot_ext;
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    if (r_acc[AW-1]) begin
                        r_acc <= r_acc + AW'(255);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_ready) begin
                        r_drive     <= w_drive;
                        r_clip      <= w_clip;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_drive_value    = r_drive;
    assign o_output_clipped = r_clip;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while a transaction is still in flight");

    a_sum_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP && !r_sum[SW-1] && !r_e[EW-1]) |=> !r_sum[SW-1])
        else $error("error sum wrapped negative on a nonnegative update");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FIN))
        else $error("result presented outside the final step");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished while the sequencer was not waiting");

endmodule

// ----- hw/rtl/pidr_mul.sv -----
module pidr_mul (
    input  logic                                i_clk,
    input  pidr_pkg::t_mul_req                  i_req,
    output logic signed [pidr_pkg::PROD_W-1:0]  o_prod
);

    logic signed [pidr_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- hw/rtl/pidr_div.sv -----
module pidr_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pidr_pkg::DIV_N_W-1:0]   i_num,
    input  logic [pidr_pkg::DIV_D_W-1:0]   i_den,
    output logic                           o_done,
    output logic [pidr_pkg::DIV_N_W-1:0]   o_quot
);

    localparam int N     = pidr_pkg::DIV_N_W;
    localparam int D     = pidr_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D-1:0]     r_rem;
    logic [D-1:0]     r_den;
    logic [N-1:0]     r_quot;

    logic [D:0]       w_trial;
    logic [D:0]       w_diff;
    logic             w_ge;
    logic [D-1:0]     n_rem;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quot[N-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[D-1:0] : w_trial[D-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[N-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- bench/pidr_drive_checker.sv -----
`timescale 1ns / 1ps

module pidr_drive_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pidr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pidr_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic signed [pidr_pkg::DATA_W-1:0] i_measured_value,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [pidr_pkg::DATA_W-1:0] i_drive_value,
    input  logic                               i_output_clipped,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    localparam int DW = pidr_pkg::DATA_W;

    typedef struct {
        logic signed [DW-1:0] drive;
        logic                 clipped;
    } t_drive_rec;

    localparam longint SUM_HI = 64'sd2147483647;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam longint OUT_HI = 64'sd32767;
    localparam longint OUT_LO = -64'sd32768;

    t_drive_rec           drive_q[$];
    logic signed [DW-1:0] setpoint_r;
    logic signed [DW-1:0] kp_r;
    logic signed [DW-1:0] ki_r;
    logic signed [DW-1:0] kd_r;
    logic [DW-1:0]        period_r;
    longint               err_sum_r;
    longint               prev_err_r;
    int                   fails = 0;

    task automatic predict_drive(input logic signed [DW-1:0] meas);
        longint     sp, kp, ki, kd, per;
        longint     err, sum, p_term, i_term, d_term, acc, y, sat;
        t_drive_rec rec;
        begin
            sp  = setpoint_r;
            kp  = kp_r;
            ki  = ki_r;
            kd  = kd_r;
            per = period_r;
            // zero period acts as one
            if (per == 0)
                per = 1;
            err = sp - longint'(meas);
            sum = err_sum_r + err;
            if (sum > SUM_HI)
                sum = SUM_HI;
            else if (sum < SUM_LO)
                sum = SUM_LO;
            p_term = kp * err;
            i_term = ki * per * sum;
            d_term = (kd * (err - prev_err_r)) / per;
            acc    = p_term + i_term + d_term;
            y      = acc / 256;
            sat    = (y > OUT_HI) ? OUT_HI : (y < OUT_LO) ? OUT_LO : y;
            rec.drive   = sat[DW-1:0];
            rec.clipped = (sat != y);
            err_sum_r   = sum;
            prev_err_r  = err;
            drive_q.push_back(rec);
        end
    endtask

    always @(posedge i_clk) begin
        t_drive_rec want;
        if (!i_rst_n) begin
            setpoint_r = '0;
            kp_r       = '0;
            ki_r       = '0;
            kd_r       = '0;
            period_r   = 1;
            err_sum_r  = 0;
            prev_err_r = 0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pidr_pkg::REG_SETPOINT:   setpoint_r = i_cfg_data;
                    pidr_pkg::REG_PROP_GAIN:  kp_r       = i_cfg_data;
                    pidr_pkg::REG_INTEG_GAIN: ki_r       = i_cfg_data;
                    pidr_pkg::REG_DERIV_GAIN: kd_r       = i_cfg_data;
                    pidr_pkg::REG_PERIOD:     period_r   = i_cfg_data;
                    default: ;
                endcase
            end
            // retire the oldest result before queuing a new sample
            if (i_out_valid && i_out_ready) begin
                if (drive_q.size() == 0) begin
                    $error("drive_value: expected none, actual %0d", i_drive_value);
                    fails++;
                end else begin
                    want = drive_q.pop_front();
                    if (i_drive_value !== want.drive) begin
                        $error("drive_value: expected %0d, actual %0d",
                               want.drive, i_drive_value);
                        fails++;
                    end
                    if (i_output_clipped !== want.clipped) begin
                        $error("output_clipped: expected %0b, actual %0b",
                               want.clipped, i_output_clipped);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_drive(i_measured_value);
        end
        o_pending    <= drive_q.size();
        o_fail_count <= fails;
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int DW = pidr_pkg::DATA_W;
    localparam int IW = pidr_pkg::CFG_IDX_W;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_we         = 1'b0;
    logic [IW-1:0]        i_cfg_idx        = '0;
    logic [DW-1:0]        i_cfg_data       = '0;
    logic                 i_valid          = 1'b0;
    logic signed [DW-1:0] i_measured_value = '0;
    logic                 i_ready          = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic signed [DW-1:0] o_drive_value;
    logic                 o_output_clipped;

    int            fail_count;
    int            pending;
    int            send_idle    = 0;
    int            recv_stall   = 0;
    logic [DW-1:0] cur_setpoint = '0;

    pid_regulator i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_measured_value (i_measured_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_drive_value    (o_drive_value),
        .o_output_clipped (o_output_clipped)
    );

    pidr_drive_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_measured_value (i_measured_value),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_drive_value    (o_drive_value),
        .i_output_clipped (o_output_clipped),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // leaves the write enable high so back-to-back writes need no toggle
    task automatic cfg_write(input logic [IW-1:0] idx, input logic [DW-1:0] data);
        begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= data;
            @(posedge i_clk);
        end
    endtask

    task automatic set_gains(input logic [DW-1:0] sp, kp, ki, kd, per);
        begin
            cfg_write(pidr_pkg::REG_SETPOINT, sp);
            cfg_write(pidr_pkg::REG_PROP_GAIN, kp);
            cfg_write(pidr_pkg::REG_INTEG_GAIN, ki);
            cfg_write(pidr_pkg::REG_DERIV_GAIN, kd);
            cfg_write(pidr_pkg::REG_PERIOD, per);
            // unmapped index: must leave every register alone
            cfg_write(IW'($urandom_range(int'(pidr_pkg::REG_PERIOD) + 1, (1 << IW) - 1)),
                      DW'($urandom));
            i_cfg_we     <= 1'b0;
            cur_setpoint = sp;
        end
    endtask

    task automatic send_item(input logic [DW-1:0] meas);
        begin
            while ($urandom_range(0, 99) < send_idle) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid          <= 1'b1;
            i_measured_value <= meas;
            do
                @(posedge i_clk);
            while (!o_ready);
        end
    endtask

    // hold the sender until every outstanding transaction has returned
    task automatic drain_results();
        begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0)
                @(posedge i_clk);
        end
    endtask

    initial begin
        logic [DW-1:0] v;
        int            pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: all gains zero
        send_item(16'h0000);
        send_item(16'h8000);
        send_item(16'h7FFF);
        drain_results();

        // unity proportional gain: drive follows the error, clips once it passes 32767
        set_gains(16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0001);
        send_item(16'h7FFF);
        send_item(16'h8000);
        send_item(16'hFFFF);
        send_item(16'h0001);
        drain_results();

        // zero period with extreme gains
        set_gains(16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000);
        send_item(16'h8000);
        send_item(16'h7FFF);
        send_item(16'h0000);
        send_item(16'h1234);
        drain_results();

        // largest period, most negative setpoint, proportional and derivative gains, largest integral gain
        set_gains(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_item(16'h7FFF);
        send_item(16'h8000);
        send_item(16'h0000);
        drain_results();

        // fractional gains: both divisions truncate toward zero
        set_gains(16'h0005, 16'h0080, 16'h0000, 16'h0100, 16'h0003);
        send_item(16'h0002);
        send_item(16'h0008);
        send_item(16'h0005);
        send_item(16'h0007);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 72; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 72; end
                default: begin send_idle = 17; recv_stall = 17; end
            endcase
            for (int seg = 0; seg < 2; seg++) begin
                case ($urandom_range(0, 5))
                    0: set_gains(DW'($urandom),
                                 DW'($urandom_range(0, 1023)) - 16'd512,
                                 DW'($urandom_range(0, 6)) - 16'd3,
                                 DW'($urandom_range(0, 1023)) - 16'd512,
                                 DW'($urandom_range(1, 20)));
                    1: set_gains(DW'($urandom), DW'($urandom), DW'($urandom),
                                 DW'($urandom), DW'($urandom));
                    2: set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
                    3: set_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
                    4: set_gains(DW'($urandom),
                                 DW'($urandom_range(0, 4095)) - 16'd2048,
                                 DW'($urandom_range(0, 2)) - 16'd1,
                                 DW'($urandom_range(0, 4095)) - 16'd2048,
                                 16'h0000);
                    default: set_gains(DW'($urandom), DW'($urandom), 16'h0000,
                                       DW'($urandom), DW'($urandom));
                endcase
                for (int n = 0; n < 200; n++) begin
                    if (phase == 1 && seg == 0 && n == 100)
                        drain_results();
                    pick = $urandom_range(0, 99);
                    // mostly track the setpoint closely, sometimes jump anywhere
                    if (pick < 70)
                        v = cur_setpoint + DW'($urandom_range(0, 128)) - 16'd64;
                    else if (pick < 88)
                        v = DW'($urandom);
                    else begin
                        case ($urandom_range(0, 3))
                            0: v = 16'h8000;
                            1: v = 16'h7FFF;
                            2: v = 16'h0000;
                            default: v = 16'hFFFF;
                        endcase
                    end
                    send_item(v);
                end
                drain_results();
            end
        end

        // push the error sum hard positive, then pull it back with the opposite error
        send_idle  = 0;
        recv_stall = 0;
        set_gains(16'h7FFF, 16'h0000, 16'h0001, 16'h0100, 16'h0001);
        repeat (20) send_item(16'h8000);
        repeat (3) send_item(16'h7FFF);
        drain_results();
        set_gains(16'h8000, 16'h0000, 16'h0001, 16'h0100, 16'h0001);
        repeat (3) send_item(16'h7FFF);
        drain_results();

        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
